>>> rtl/core/ddoi_pkg.sv
// Shared types, register indexes, reset values and tables of the odometry integrator.
// Used by diff_drive_odometry_integrator_core; depends on nothing else.
`default_nettype none

package ddoi_pkg;

  // Beat layouts of the two streaming channels.
  typedef struct packed {
    logic               action;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic        [15:0] elapsed_ms;
    logic signed [31:0] fix_x;
    logic signed [31:0] fix_y;
    logic        [31:0] fix_heading;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] angular_velocity;
  } out_beat_t;

  // Configuration register indexes.
  localparam logic [1:0] CfgDistancePerTick    = 2'd0;
  localparam logic [1:0] CfgSpeedToVelocity    = 2'd1;
  localparam logic [1:0] CfgTurnsPerMetre      = 2'd2;
  localparam logic [1:0] CfgInvWheelSeparation = 2'd3;

  localparam logic [31:0] RstDistancePerTick    = 32'd18301;
  localparam logic [31:0] RstSpeedToVelocity    = 32'd4997420;
  localparam logic [31:0] RstTurnsPerMetre      = 32'd6846542;
  localparam logic [31:0] RstInvWheelSeparation = 32'd43018003;

  // Action codes of an input beat.
  localparam logic ActSample = 1'b0;
  localparam logic ActFix    = 1'b1;

  // Serial multiplier geometry: signed multiplicand, 32-bit multiplier.
  localparam int MulAW = 57;
  localparam int MulBW = 32;
  localparam int ProdW = MulAW + 1 + MulBW;
  localparam int CntW  = $clog2(MulBW);

  localparam int CordicStepsDef = 24;
  localparam int CordicW        = 34;
  localparam logic signed [CordicW-1:0] CordicStart = 34'sd652032874;

  // Arctangent of 2^-k in 2^-32 turns.
  function automatic logic [31:0] atan_turns(input logic [4:0] k);
    logic [31:0] r;
    case (k)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Saturates a wide signed value to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [ProdW-1:0] v);
    logic [31:0] r;
    if ((&v[ProdW-1:31]) || (~|v[ProdW-1:31])) begin
      r = v[31:0];
    end else if (v[ProdW-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/diff_drive_odometry_integrator_core.sv
// Differential-drive wheel odometry integrator, top level.
// Depends on ddoi_pkg for beat types, register indexes, the arctangent table and saturation.
`default_nettype none

// An encoder sample beat (action 0) turns the tick differences since the previous
// sample into wheel travel and advances the pose by midpoint-heading dead reckoning;
// the first sample after reset primes the stored counts and so sees no travel. A fix beat (action 1)
// latches an absolute pose, which the next sample with nonzero elapsed time applies
// in place of integrating. A sample with zero elapsed time only updates the stored
// counts. Each sample with nonzero elapsed time yields one output beat with the
// pose and the linear and angular speed. A fix beat and a zero-elapsed sample are
// taken without leaving idle. All products go through one radix-2 shift-add multiplier
// that retires one multiplier bit a cycle, with an operand load before each multiply
// and a result store after it; an integrating sample runs eight multiplies plus the
// CORDIC, one rotation a cycle, and a sample that applies a fix runs six multiplies
// and no CORDIC. One item is worked on at a time; the next input beat is taken
// as soon as the result sits in the output register, even before it is drained.
// Configuration registers are written through a plain write port and must only be
// written while the block is idle.
module diff_drive_odometry_integrator_core #(
  parameter int CORDIC_STEPS = ddoi_pkg::CordicStepsDef
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire ddoi_pkg::in_beat_t   in_beat_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output ddoi_pkg::out_beat_t       out_beat_o,
  input  wire                       cfg_we_i,
  input  wire [1:0]                 cfg_idx_i,
  input  wire [31:0]                cfg_data_i
);

  localparam int MulAW   = ddoi_pkg::MulAW;
  localparam int MulBW   = ddoi_pkg::MulBW;
  localparam int ProdW   = ddoi_pkg::ProdW;
  localparam int CntW    = ddoi_pkg::CntW;
  localparam int CordicW = ddoi_pkg::CordicW;

  // Sequencer states.
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StLoad   = 3'd1;
  localparam logic [2:0] StMul    = 3'd2;
  localparam logic [2:0] StStore  = 3'd3;
  localparam logic [2:0] StCordic = 3'd4;
  localparam logic [2:0] StQmap   = 3'd5;
  localparam logic [2:0] StDone   = 3'd6;

  // Multiply operations, in the order they run.
  localparam logic [2:0] OpSum  = 3'd0;  // (dl + dr) * distance_per_tick
  localparam logic [2:0] OpDif  = 3'd1;  // (dr - dl) * distance_per_tick
  localparam logic [2:0] OpTh   = 3'd2;  // wheel difference * turns_per_metre
  localparam logic [2:0] OpVel  = 3'd3;  // (ls + rs) * speed_to_velocity
  localparam logic [2:0] OpAng  = 3'd4;  // (ls - rs) * inv_wheel_separation
  localparam logic [2:0] OpW    = 3'd5;  // previous * speed_to_velocity
  localparam logic [2:0] OpX    = 3'd6;  // ds * cos
  localparam logic [2:0] OpY    = 3'd7;  // ds * sin

  // Configuration registers.
  logic [31:0] dpt_q, stv_q, tpm_q, iws_q;

  // Persistent odometry state.
  logic [31:0] last_l_q, last_r_q;
  logic        primed_q, fix_pending_q;
  logic [31:0] pose_x_q, pose_y_q, pose_h_q;
  logic [31:0] fix_x_q, fix_y_q, fix_h_q;

  // Per-item working registers.
  logic [2:0]                 state_q, state_d;
  logic [2:0]                 op_q, op_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic signed [31:0]         diffl_q, diffr_q;
  logic signed [15:0]         ls_q, rs_q;
  logic signed [55:0]         ds_q;
  logic signed [MulAW-1:0]    t_q;
  logic [31:0]                dth_q, half_q;
  logic [31:0]                v_q, w_q;
  logic [31:0]                dx_q, dy_q;
  logic signed [31:0]         c_q, s_q;

  // Serial multiplier.
  logic signed [MulAW-1:0]    mul_a_q;
  logic                       mul_sgn_q;
  logic signed [MulAW:0]      hi_q;
  logic [MulBW-1:0]           lo_q;

  // CORDIC.
  logic signed [CordicW-1:0]  x_q, y_q, z_q;
  logic [1:0]                 quad_q;

  // Output register.
  logic                       out_valid_q;
  ddoi_pkg::out_beat_t        out_beat_q;

  logic in_acc, out_free;
  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // Differences of an incoming sample against the stored counts.
  logic [31:0] base_l, base_r;
  assign base_l = primed_q ? last_l_q : in_beat_i.left_count;
  assign base_r = primed_q ? last_r_q : in_beat_i.right_count;

  // Operand selection for the next multiply.
  logic signed [32:0]       sum_lr, dif_rl;
  logic signed [16:0]       sp_sum, sp_dif;
  logic signed [MulAW-1:0]  op_a;
  logic [MulBW-1:0]         op_b;
  logic                     op_sgn;

  always_comb begin
    sum_lr = 33'(diffl_q) + 33'(diffr_q);
    dif_rl = 33'(diffr_q) - 33'(diffl_q);
    sp_sum = 17'(ls_q) + 17'(rs_q);
    sp_dif = 17'(ls_q) - 17'(rs_q);
    op_sgn = 1'b0;
    unique case (op_q)
      OpSum: begin
        op_a = MulAW'(sum_lr);
        op_b = dpt_q;
      end
      OpDif: begin
        op_a = MulAW'(dif_rl);
        op_b = dpt_q;
      end
      OpTh: begin
        op_a = t_q;
        op_b = tpm_q;
      end
      OpVel: begin
        op_a = MulAW'(sp_sum);
        op_b = stv_q;
      end
      OpAng: begin
        op_a = MulAW'(sp_dif);
        op_b = iws_q;
      end
      OpW: begin
        op_a = t_q;
        op_b = stv_q;
      end
      OpX: begin
        op_a = MulAW'(ds_q);
        op_b = c_q;
        op_sgn = 1'b1;
      end
      default: begin
        op_a = MulAW'(ds_q);
        op_b = s_q;
        op_sgn = 1'b1;
      end
    endcase
  end

  // One multiplier bit a cycle; a signed multiplier's top bit weighs negative.
  logic                     mul_last, mul_neg;
  logic signed [MulAW:0]    a_ext, addend, mul_sum;
  logic signed [ProdW-1:0]  prod;

  always_comb begin
    mul_last = (cnt_q == CntW'(MulBW - 1));
    mul_neg  = mul_sgn_q && mul_last;
    a_ext    = (MulAW + 1)'(mul_a_q);
    if (!lo_q[0]) begin
      addend = '0;
    end else if (mul_neg) begin
      addend = -a_ext;
    end else begin
      addend = a_ext;
    end
    mul_sum = hi_q + addend;
    prod    = $signed({hi_q, lo_q});
  end

  logic signed [ProdW-1:0] v_sh, w_sh;
  assign v_sh = prod >>> 17;
  assign w_sh = prod >>> 40;

  // Angle for the CORDIC: the heading at the middle of the step, folded to a quadrant.
  logic [31:0] ang, ang_rot, ang_res;
  logic [1:0]  ang_q;
  assign ang     = pose_h_q + half_q;
  assign ang_rot = ang + 32'h2000_0000;
  assign ang_q   = ang_rot[31:30];
  assign ang_res = ang - {ang_q, 30'd0};

  // One CORDIC rotation.
  logic signed [CordicW-1:0] xs, ys, at_ext;
  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign at_ext = $signed({2'b00, ddoi_pkg::atan_turns(5'(cnt_q))});

  // Pose after this item.
  logic [31:0] nx, ny, nh;
  assign nx = fix_pending_q ? fix_x_q : pose_x_q + dx_q;
  assign ny = fix_pending_q ? fix_y_q : pose_y_q + dy_q;
  assign nh = fix_pending_q ? fix_h_q : pose_h_q + dth_q;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && (in_beat_i.action == ddoi_pkg::ActSample) &&
            (in_beat_i.elapsed_ms != 16'd0)) begin
          state_d = StLoad;
          op_d    = OpSum;
        end
      end
      StLoad: begin
        state_d = StMul;
        cnt_d   = '0;
      end
      StMul: begin
        cnt_d = cnt_q + CntW'(1);
        if (mul_last) begin
          state_d = StStore;
        end
      end
      StStore: begin
        cnt_d = '0;
        if (op_q == OpY) begin
          state_d = StDone;
        end else if (op_q == OpW) begin
          state_d = fix_pending_q ? StDone : StCordic;
        end else begin
          state_d = StLoad;
          op_d    = op_q + 3'd1;
        end
      end
      StCordic: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(CORDIC_STEPS - 1)) begin
          state_d = StQmap;
        end
      end
      StQmap: begin
        state_d = StLoad;
        op_d    = OpX;
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state and persistent state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      op_q          <= OpSum;
      cnt_q         <= '0;
      dpt_q         <= ddoi_pkg::RstDistancePerTick;
      stv_q         <= ddoi_pkg::RstSpeedToVelocity;
      tpm_q         <= ddoi_pkg::RstTurnsPerMetre;
      iws_q         <= ddoi_pkg::RstInvWheelSeparation;
      last_l_q      <= '0;
      last_r_q      <= '0;
      primed_q      <= 1'b0;
      fix_pending_q <= 1'b0;
      pose_x_q      <= '0;
      pose_y_q      <= '0;
      pose_h_q      <= '0;
      fix_x_q       <= '0;
      fix_y_q       <= '0;
      fix_h_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ddoi_pkg::CfgDistancePerTick:    dpt_q <= cfg_data_i;
          ddoi_pkg::CfgSpeedToVelocity:    stv_q <= cfg_data_i;
          ddoi_pkg::CfgTurnsPerMetre:      tpm_q <= cfg_data_i;
          ddoi_pkg::CfgInvWheelSeparation: iws_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        if (in_beat_i.action == ddoi_pkg::ActFix) begin
          fix_x_q       <= in_beat_i.fix_x;
          fix_y_q       <= in_beat_i.fix_y;
          fix_h_q       <= in_beat_i.fix_heading;
          fix_pending_q <= 1'b1;
        end else begin
          last_l_q <= in_beat_i.left_count;
          last_r_q <= in_beat_i.right_count;
          primed_q <= 1'b1;
        end
      end
      if ((state_q == StDone) && out_free) begin
        pose_x_q      <= nx;
        pose_y_q      <= ny;
        pose_h_q      <= nh;
        fix_pending_q <= 1'b0;
        out_valid_q   <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      diffl_q <= in_beat_i.left_count - base_l;
      diffr_q <= in_beat_i.right_count - base_r;
      ls_q    <= in_beat_i.left_speed;
      rs_q    <= in_beat_i.right_speed;
    end
    if (state_q == StLoad) begin
      mul_a_q   <= op_a;
      mul_sgn_q <= op_sgn;
      hi_q      <= '0;
      lo_q      <= op_b;
    end
    if (state_q == StMul) begin
      hi_q <= {mul_sum[MulAW], mul_sum[MulAW:1]};
      lo_q <= {mul_sum[0], lo_q[MulBW-1:1]};
    end
    if (state_q == StStore) begin
      unique case (op_q)
        OpSum: ds_q <= prod[64:9];
        OpDif: t_q  <= prod[MulAW-1:0];
        OpTh: begin
          dth_q  <= prod[55:24];
          half_q <= prod[56:25];
        end
        OpVel: v_q <= ddoi_pkg::sat32(v_sh);
        OpAng: t_q <= MulAW'($signed(prod[48:0]));
        OpW: begin
          w_q    <= ddoi_pkg::sat32(w_sh);
          x_q    <= ddoi_pkg::CordicStart;
          y_q    <= '0;
          z_q    <= CordicW'($signed(ang_res));
          quad_q <= ang_q;
        end
        OpX: dx_q <= prod[69:38];
        default: dy_q <= prod[69:38];
      endcase
    end
    if (state_q == StCordic) begin
      if (!z_q[CordicW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at_ext;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at_ext;
      end
    end
    if (state_q == StQmap) begin
      case (quad_q)
        2'd0: begin
          c_q <= 32'(x_q);
          s_q <= 32'(y_q);
        end
        2'd1: begin
          c_q <= 32'(-y_q);
          s_q <= 32'(x_q);
        end
        2'd2: begin
          c_q <= 32'(-x_q);
          s_q <= 32'(-y_q);
        end
        default: begin
          c_q <= 32'(y_q);
          s_q <= 32'(-x_q);
        end
      endcase
    end
    if ((state_q == StDone) && out_free) begin
      out_beat_q.pos_x            <= nx;
      out_beat_q.pos_y            <= ny;
      out_beat_q.heading          <= nh;
      out_beat_q.linear_velocity  <= v_q;
      out_beat_q.angular_velocity <= w_q;
    end
  end

`ifndef SYNTHESIS
  // A fix beat latches a pending fix and leaves the sequencer idle.
  a_fix_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_beat_i.action == ddoi_pkg::ActFix) |=> fix_pending_q && in_ready_o)
    else $error("fix beat did not latch a pending fix");

  // A sample with zero elapsed time gives no work.
  a_zero_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_beat_i.action == ddoi_pkg::ActSample) &&
    (in_beat_i.elapsed_ms == 16'd0) |=> in_ready_o && primed_q)
    else $error("zero-elapsed sample started work");

  // A working sample starts with the first multiply.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_beat_i.action == ddoi_pkg::ActSample) &&
    (in_beat_i.elapsed_ms != 16'd0) |=> (state_q == StLoad) && (op_q == OpSum))
    else $error("sample did not start the multiply chain");

  // Finishing an item posts a result and clears a pending fix.
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) && out_free |=> out_valid_o && !fix_pending_q && in_ready_o)
    else $error("finished item did not post its result");
`endif

endmodule

`default_nettype wire
